### rtl/core/region_strip_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Region strip decoder unit: assertion macros
// Shared concurrent assertion forms used by the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef REGION_STRIP_DECODER_UNIT_DEFINES_SVH
`define REGION_STRIP_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define RSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define RSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/rsd_pkg.sv
// ----------------------------------------------------------------------------
// Region strip decoder package
// Widths, parse phase codes, byte masks and the structs shared by the decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

	// Internal coordinate width; coordinates wrap at this width.
	localparam int COORD_BITS = 12;
	// Width of the coordinate fields on the ports.
	localparam int PIX_W = 12;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [PIX_W-1:0]      pix_t;
	typedef logic [7:0]            byte_t;
	typedef logic [15:0]           colour_t;
	typedef logic [2:0]            phase_t;

	localparam phase_t PH_IDLE      = 3'd0;
	localparam phase_t PH_HDR_Y     = 3'd1;
	localparam phase_t PH_BULK_W    = 3'd2;
	localparam phase_t PH_BULK_H    = 3'd3;
	localparam phase_t PH_BULK_DX   = 3'd4;
	localparam phase_t PH_BULK_DY   = 3'd5;
	localparam phase_t PH_STRIP     = 3'd6;
	localparam phase_t PH_STRIP_OFF = 3'd7;

	localparam byte_t HIGH_BIT = 8'h80;
	localparam byte_t LOW7     = 8'h7F;

	localparam logic KIND_FILL = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		phase_t  phase;
		coord_t  base_x;
		coord_t  cursor_y;
		byte_t   held_width;
		byte_t   held_height;
		byte_t   held_dx;
		colour_t held_colour;
		logic    held_use_offset;
	} parse_state_t;

	typedef struct packed {
		logic    kind;
		pix_t    x;
		pix_t    y;
		byte_t   width;
		byte_t   height;
		colour_t colour;
	} rect_cmd_t;

	// Port coordinates are the low bits of the wrapped internal coordinate.
	function automatic pix_t to_pix(input coord_t c);
		return PIX_W'(c);
	endfunction

	function automatic coord_t to_coord(input pix_t p);
		return COORD_BITS'(p);
	endfunction

endpackage

### rtl/core/rsd_parse.sv
// ----------------------------------------------------------------------------
// Region strip decoder: byte parser
// Next-state and command logic for one encoded byte of a region description.
// ----------------------------------------------------------------------------
module rsd_parse (
	input  rsd_pkg::parse_state_t state,
	input  rsd_pkg::byte_t        data_byte,
	input  logic                  start_region,
	input  rsd_pkg::pix_t         origin_x,
	input  rsd_pkg::pix_t         origin_y,
	input  rsd_pkg::colour_t      fill_colour,
	input  logic                  use_offset,
	output rsd_pkg::parse_state_t next_state,
	output logic                  emit,
	output rsd_pkg::rect_cmd_t    cmd
);
	import rsd_pkg::*;

	coord_t byte_c;
	coord_t low7_c;
	coord_t strip_row;

	assign byte_c    = COORD_BITS'(data_byte);
	assign low7_c    = COORD_BITS'(data_byte & LOW7);
	assign strip_row = ((data_byte & HIGH_BIT) != '0) ? state.cursor_y + COORD_BITS'(1)
		: state.cursor_y;

	always_comb begin
		next_state = state;
		emit       = 1'b0;
		cmd        = '0;
		cmd.kind   = KIND_FILL;
		if (start_region) begin
			// A start byte always opens a new region, abandoning any open one.
			next_state.held_colour     = fill_colour;
			next_state.held_use_offset = use_offset;
			next_state.base_x          = use_offset ? to_coord(origin_x) + byte_c
				: to_coord(origin_x);
			next_state.cursor_y        = to_coord(origin_y);
			next_state.held_width      = '0;
			next_state.held_height     = '0;
			next_state.held_dx         = '0;
			next_state.phase           = PH_HDR_Y;
		end else begin
			unique case (state.phase)
				PH_IDLE: begin
					next_state.phase = PH_IDLE;
				end
				PH_HDR_Y: begin
					if (state.held_use_offset) begin
						next_state.cursor_y = state.cursor_y + byte_c;
					end
					next_state.phase = PH_BULK_W;
				end
				PH_BULK_W: begin
					next_state.held_width = data_byte;
					next_state.phase      = (data_byte != '0) ? PH_BULK_H : PH_STRIP;
				end
				PH_BULK_H: begin
					next_state.held_height = data_byte;
					next_state.phase       = PH_BULK_DX;
				end
				PH_BULK_DX: begin
					next_state.held_dx = data_byte;
					next_state.phase   = PH_BULK_DY;
				end
				PH_BULK_DY: begin
					emit             = 1'b1;
					cmd.x            = to_pix(state.base_x + COORD_BITS'(state.held_dx));
					cmd.y            = to_pix(state.cursor_y + byte_c);
					cmd.width        = state.held_width;
					cmd.height       = state.held_height;
					cmd.colour       = state.held_colour;
					next_state.phase = PH_STRIP;
				end
				PH_STRIP: begin
					priority if ((data_byte & HIGH_BIT) != '0) begin
						next_state.cursor_y = state.cursor_y + low7_c;
					end else if (data_byte != '0) begin
						next_state.held_width = data_byte;
						next_state.phase      = PH_STRIP_OFF;
					end else begin
						emit             = 1'b1;
						cmd.kind         = KIND_END;
						next_state.phase = PH_IDLE;
					end
				end
				PH_STRIP_OFF: begin
					emit                = 1'b1;
					next_state.cursor_y = strip_row;
					cmd.x               = to_pix(state.base_x + low7_c);
					cmd.y               = to_pix(strip_row);
					cmd.width           = state.held_width;
					cmd.height          = 8'd1;
					cmd.colour          = state.held_colour;
					next_state.phase    = PH_STRIP;
				end
				default: begin
					next_state.phase = PH_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/region_strip_decoder_unit.sv
// ----------------------------------------------------------------------------
// Region strip decoder unit
// Turns a byte stream describing a screen region into rectangle-fill commands.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                     Payload
//  -------   ---------------------------   ------------------------------------
//  item      item_valid / item_stall       data_byte, start_region, origin_x,
//                                          origin_y, fill_colour, use_offset
//  result    result_valid / result_stall   kind, rect_x, rect_y, rect_width,
//                                          rect_height, colour_out
//
//  One byte is taken per cycle; a command it causes is visible on the result
//  port in the cycle after its transfer. The single result register sets the
//  figure: a byte is refused only while that register holds a command that
//  the consumer is stalling. Reset puts the parser in its idle phase and
//  empties the result register.
//
// ----------------------------------------------------------------------------
module region_strip_decoder_unit (
	input  logic              clk,
	input  logic              arst_n,
	// Input byte channel.
	input  logic              item_valid,
	output logic              item_stall,
	input  rsd_pkg::byte_t    data_byte,
	input  logic              start_region,
	input  rsd_pkg::pix_t     origin_x,
	input  rsd_pkg::pix_t     origin_y,
	input  rsd_pkg::colour_t  fill_colour,
	input  logic              use_offset,
	// Result channel.
	output logic              result_valid,
	input  logic              result_stall,
	output logic              kind,
	output rsd_pkg::pix_t     rect_x,
	output rsd_pkg::pix_t     rect_y,
	output rsd_pkg::byte_t    rect_width,
	output rsd_pkg::byte_t    rect_height,
	output rsd_pkg::colour_t  colour_out
);
	import rsd_pkg::*;

	// Parser state: phase, working column base, current row and the values
	// held between the bytes of one record.
	parse_state_t state_q;
	parse_state_t next_state;

	// Result register and its valid flag.
	logic      result_valid_q;
	rect_cmd_t result_q;

	logic      emit;
	rect_cmd_t cmd;
	logic      item_xfer;

	// The result register can take a new command whenever it is empty or its
	// current command leaves in this cycle, so the stall is just that.
	assign item_stall = result_valid_q && result_stall;
	assign item_xfer  = item_valid && !item_stall;

	rsd_parse u_parse (
		.state        (state_q),
		.data_byte    (data_byte),
		.start_region (start_region),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.fill_colour  (fill_colour),
		.use_offset   (use_offset),
		.next_state   (next_state),
		.emit         (emit),
		.cmd          (cmd)
	);

	// The parser state moves only on an accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
		end else if (item_xfer) begin
			state_q <= next_state;
		end
	end

	// A transfer that produces a command refills the register; otherwise the
	// register empties once the consumer takes its command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_xfer) begin
			result_valid_q <= emit || (result_valid_q && result_stall);
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer && emit) begin
			result_q <= cmd;
		end
	end

	assign result_valid = result_valid_q;
	assign kind         = result_q.kind;
	assign rect_x       = result_q.x;
	assign rect_y       = result_q.y;
	assign rect_width   = result_q.width;
	assign rect_height  = result_q.height;
	assign colour_out   = result_q.colour;

endmodule

### rtl/core/rsd_checker.sv
// ----------------------------------------------------------------------------
// Region strip decoder checker
// Port-level assertions on the decoder's handshakes and result contents.
// ----------------------------------------------------------------------------
`include "region_strip_decoder_unit_defines.svh"

module rsd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input logic             kind,
	input rsd_pkg::pix_t    rect_x,
	input rsd_pkg::pix_t    rect_y,
	input rsd_pkg::byte_t   rect_width,
	input rsd_pkg::byte_t   rect_height,
	input rsd_pkg::colour_t colour_out
);
	import rsd_pkg::*;

	// An end-of-region command carries all-zero geometry and colour.
	`RSD_ASSERT_IMPLY(a_end_zero, clk, arst_n, result_valid && kind == KIND_END, rect_x == '0 && rect_y == '0 && rect_width == '0 && rect_height == '0 && colour_out == '0, "end command with nonzero fields")

	// Every fill command has a nonzero width.
	`RSD_ASSERT_IMPLY(a_fill_width, clk, arst_n, result_valid && kind == KIND_FILL, rect_width != '0, "fill command with zero width")

	// The input side is held off only while a command waits to be taken.
	`RSD_ASSERT_IMPLY(a_stall_cause, clk, arst_n, item_stall, result_valid && result_stall, "input stalled without a waiting command")

	// A new command only follows an input transfer.
	`RSD_ASSERT_IMPLY(a_result_source, clk, arst_n, $rose(result_valid), $past(item_valid && !item_stall), "command without an input transfer")

	// A stalled command stays in place.
	`RSD_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(kind) && $stable(rect_x) && $stable(rect_y), "stalled command changed")

endmodule

bind region_strip_decoder_unit rsd_checker u_rsd_checker (.*);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Region strip decoder unit testbench
// Sends byte streams that describe regions to the decoder and checks each
// rectangle-fill and end-of-region command against a cycle-free decoder
// model. A short scripted set of regions comes first, then random regions,
// with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	import rsd_pkg::*;

	// One encoded byte together with the side fields of the input channel.
	typedef struct packed {
		byte_t   data;
		logic    start;
		pix_t    ox;
		pix_t    oy;
		colour_t colour;
		logic    offs;
	} region_byte_t;

	// A scripted byte. When fixed is set, want is the command that the byte
	// must produce, typed in by hand; otherwise the decoder model decides.
	typedef struct packed {
		region_byte_t item;
		logic         fixed;
		rect_cmd_t    want;
	} script_row_t;

	localparam rect_cmd_t NO_RECT = '0;
	localparam int RANDOM_BYTES = 500;
	localparam int LONG_HOLD = 80;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	byte_t   data_byte;
	logic    start_region;
	pix_t    origin_x;
	pix_t    origin_y;
	colour_t fill_colour;
	logic    use_offset;
	logic    result_valid;
	logic    result_stall;
	logic    kind;
	pix_t    rect_x;
	pix_t    rect_y;
	byte_t   rect_width;
	byte_t   rect_height;
	colour_t colour_out;

	region_strip_decoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.data_byte    (data_byte),
		.start_region (start_region),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.fill_colour  (fill_colour),
		.use_offset   (use_offset),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.rect_x       (rect_x),
		.rect_y       (rect_y),
		.rect_width   (rect_width),
		.rect_height  (rect_height),
		.colour_out   (colour_out)
	);

	// The decoder model keeps its own copy of the parse state. It is advanced
	// once for every byte transfer on the input channel.
	phase_t  dec_phase  = PH_IDLE;
	coord_t  dec_col    = '0;
	coord_t  dec_row    = '0;
	byte_t   dec_width  = '0;
	byte_t   dec_height = '0;
	byte_t   dec_dx     = '0;
	colour_t dec_colour = '0;
	logic    dec_offs   = 1'b0;

	// Commands still owed by the block, oldest first.
	rect_cmd_t pending_rects[$];

	int err_count    = 0;
	int rects_seen   = 0;
	int bytes_parsed = 0;
	int burst_left   = 0;
	bit drain_req    = 1'b0;

	// Decodes one byte. Returns 1 and fills cmd when the byte completes a
	// command. A byte with start_region set always opens a new region, which
	// silently drops any region that was still being parsed.
	function automatic logic decode_byte(input region_byte_t it, output rect_cmd_t cmd);
		byte_t  b;
		coord_t cx;
		coord_t cy;
		b = it.data;
		cmd = NO_RECT;
		if (it.start) begin
			dec_colour = it.colour;
			dec_offs = it.offs;
			dec_col = coord_t'(it.ox);
			dec_row = coord_t'(it.oy);
			if (dec_offs) begin
				dec_col = dec_col + coord_t'(b);
			end
			dec_width = '0;
			dec_height = '0;
			dec_dx = '0;
			dec_phase = PH_HDR_Y;
			return 1'b0;
		end
		case (dec_phase)
			PH_IDLE: begin
				// Stray bytes between regions are dropped.
				return 1'b0;
			end
			PH_HDR_Y: begin
				if (dec_offs) begin
					dec_row = dec_row + coord_t'(b);
				end
				dec_phase = PH_BULK_W;
				return 1'b0;
			end
			PH_BULK_W: begin
				dec_width = b;
				dec_phase = (b != 8'd0) ? PH_BULK_H : PH_STRIP;
				return 1'b0;
			end
			PH_BULK_H: begin
				dec_height = b;
				dec_phase = PH_BULK_DX;
				return 1'b0;
			end
			PH_BULK_DX: begin
				dec_dx = b;
				dec_phase = PH_BULK_DY;
				return 1'b0;
			end
			PH_BULK_DY: begin
				// The bulk rectangle is placed relative to the cursor but does
				// not move it.
				cx = dec_col + coord_t'(dec_dx);
				cy = dec_row + coord_t'(b);
				cmd.kind = KIND_FILL;
				cmd.x = pix_t'(cx);
				cmd.y = pix_t'(cy);
				cmd.width = dec_width;
				cmd.height = dec_height;
				cmd.colour = dec_colour;
				dec_phase = PH_STRIP;
				return 1'b1;
			end
			PH_STRIP: begin
				if ((b & HIGH_BIT) != 8'd0) begin
					dec_row = dec_row + coord_t'(b & LOW7);
					return 1'b0;
				end
				if (b != 8'd0) begin
					dec_width = b;
					dec_phase = PH_STRIP_OFF;
					return 1'b0;
				end
				cmd.kind = KIND_END;
				dec_phase = PH_IDLE;
				return 1'b1;
			end
			PH_STRIP_OFF: begin
				if ((b & HIGH_BIT) != 8'd0) begin
					dec_row = dec_row + coord_t'(1);
				end
				cx = dec_col + coord_t'(b & LOW7);
				cmd.kind = KIND_FILL;
				cmd.x = pix_t'(cx);
				cmd.y = pix_t'(dec_row);
				cmd.width = dec_width;
				cmd.height = 8'd1;
				cmd.colour = dec_colour;
				dec_phase = PH_STRIP;
				return 1'b1;
			end
			default: begin
				dec_phase = PH_IDLE;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic region_byte_t rand_byte(input byte_t data, input logic start);
		region_byte_t it;
		it.data = data;
		it.start = start;
		it.ox = pix_t'($urandom_range(0, 4095));
		it.oy = pix_t'($urandom_range(0, 4095));
		it.colour = colour_t'($urandom_range(0, 65535));
		it.offs = logic'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic note_mismatch(input string what);
		$display("%0t ns: %s", $time, what);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			note_mismatch($sformatf("command %0d %s: got 0x%0h, expected 0x%0h",
				rects_seen, name, got, want));
		end
	endtask

	// Offers one byte and holds it until the transfer. The expectation is
	// queued at the transfer edge; the command can show up in the next cycle at
	// the earliest, so the queue is always ahead of the result checker. After
	// the transfer the sender either keeps its burst going, idles for a
	// random gap, or waits for the block to drain completely.
	task automatic offer(input region_byte_t it, input logic fixed, input rect_cmd_t want);
		rect_cmd_t cmd;
		logic      made;
		logic      ignored;
		item_valid <= 1'b1;
		data_byte <= it.data;
		start_region <= it.start;
		origin_x <= it.ox;
		origin_y <= it.oy;
		fill_colour <= it.colour;
		use_offset <= it.offs;
		do @(posedge clk); while (item_stall);
		ignored = (dec_phase == PH_IDLE) && !it.start;
		made = decode_byte(it, cmd);
		if (fixed) begin
			pending_rects.push_back(want);
		end else if (made) begin
			pending_rects.push_back(cmd);
		end
		if (!ignored) begin
			bytes_parsed++;
		end
		if (drain_req) begin
			item_valid <= 1'b0;
			do @(posedge clk); while (pending_rects.size() != 0);
			drain_req = 1'b0;
		end else if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end else begin
			burst_left--;
		end
	endtask

	// One random region. Most regions are well formed; a few are cut short
	// so that the next header restarts the parser mid-region, and a few are
	// preceded by loose bytes that land wherever the parser happens to be.
	task automatic random_region();
		byte_t stream[$];
		int    n_strips;
		int    keep;
		stream.push_back(byte_t'($urandom_range(0, 255)));
		stream.push_back(byte_t'($urandom_range(0, 255)));
		if ($urandom_range(0, 1) == 0) begin
			stream.push_back(8'd0);
		end else begin
			stream.push_back(byte_t'($urandom_range(1, 255)));
			repeat (3) stream.push_back(byte_t'($urandom_range(0, 255)));
		end
		n_strips = $urandom_range(0, 8);
		repeat (n_strips) begin
			if ($urandom_range(0, 3) == 0) begin
				stream.push_back(HIGH_BIT | byte_t'($urandom_range(0, 127)));
			end else begin
				stream.push_back(byte_t'($urandom_range(1, 127)));
				stream.push_back(byte_t'($urandom_range(0, 255)));
			end
		end
		stream.push_back(8'd0);
		if ($urandom_range(0, 9) == 0) begin
			keep = $urandom_range(1, stream.size() - 1);
			while (stream.size() > keep) void'(stream.pop_back());
		end
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				offer(rand_byte(byte_t'($urandom_range(0, 255)), 1'b0), 1'b0, NO_RECT);
			end
		end
		foreach (stream[i]) begin
			offer(rand_byte(stream[i], i == 0), 1'b0, NO_RECT);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result channel pacing. The receiver alternates spans of free flow, light
	// stalling, heavy stalling and a toggling pattern. Once, later in the run, it
	// holds off for a long stretch so that the single result register fills and
	// the block has to stall its input while the sender keeps offering bytes.
	initial begin
		int  span;
		int  mode;
		int  pace_cycles;
		bit  held;
		pace_cycles = 0;
		held = 1'b0;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			span = $urandom_range(1, 24);
			mode = $urandom_range(0, 3);
			for (int i = 0; i < span; i++) begin
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 3) == 0);
					2: result_stall <= ($urandom_range(0, 3) != 0);
					default: result_stall <= logic'(i[0]);
				endcase
				@(posedge clk);
				pace_cycles++;
			end
			if (!held && pace_cycles >= 400) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				held = 1'b1;
			end
		end
	end

	// Result checker. A command transfers on an edge where result_valid is
	// high and our stall is low; both are read before this edge's updates.
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_rects.size() == 0) begin
				note_mismatch($sformatf("unexpected command: kind %0b x %0d y %0d w %0d h %0d",
					kind, rect_x, rect_y, rect_width, rect_height));
			end else begin
				rect_cmd_t want;
				want = pending_rects.pop_front();
				check_field("kind", 16'(kind), 16'(want.kind));
				check_field("rect_x", 16'(rect_x), 16'(want.x));
				check_field("rect_y", 16'(rect_y), 16'(want.y));
				check_field("rect_width", 16'(rect_width), 16'(want.width));
				check_field("rect_height", 16'(rect_height), 16'(want.height));
				check_field("colour_out", colour_out, want.colour);
			end
			rects_seen++;
		end
	end

	// Stimulus. The script opens with a zero byte while idle (it must not end
	// anything), then a region built from all-ones extremes with offsets on
	// and coordinates that wrap, a region with offsets off and a bare strip
	// list that is abandoned by the next header, a region abandoned during
	// its bulk header, and a plain bulk region that ends normally.
	initial begin
		script_row_t script[$];
		bit          drained;
		drained = 1'b0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		data_byte <= '0;
		start_region <= 1'b0;
		origin_x <= '0;
		origin_y <= '0;
		fill_colour <= '0;
		use_offset <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero byte while idle is ignored.
		script.push_back('{'{8'h00, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		// Extremes: origin 4095 plus offset 255 wraps to 254 on both axes.
		script.push_back('{'{8'hFF, 1'b1, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b1}, 1'b0, NO_RECT});
		script.push_back('{'{8'hFF, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'hFF, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'hFF, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'hFF, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'hFF, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b1,
			'{KIND_FILL, 12'd509, 12'd509, 8'd255, 8'd255, 16'hFFFF}});
		// Largest row skip, then the widest strip with a row step and offset 127.
		script.push_back('{'{8'hFF, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h7F, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'hFF, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b1,
			'{KIND_FILL, 12'd381, 12'd382, 8'd127, 8'd1, 16'hFFFF}});
		// Offsets off: the header bytes must leave the origin alone.
		script.push_back('{'{8'hAB, 1'b1, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h55, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h00, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h01, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h00, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b1,
			'{KIND_FILL, 12'd0, 12'd0, 8'd1, 8'd1, 16'h0000}});
		script.push_back('{'{8'h01, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h80, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b1,
			'{KIND_FILL, 12'd0, 12'd1, 8'd1, 8'd1, 16'h0000}});
		// New header in the strip phase drops the region with no end command.
		script.push_back('{'{8'h10, 1'b1, 12'hFF0, 12'h800, 16'h1234, 1'b1}, 1'b0, NO_RECT});
		script.push_back('{'{8'h00, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h03, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		// New header while the bulk height is awaited.
		script.push_back('{'{8'h00, 1'b1, 12'd100, 12'd200, 16'h0F0F, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h00, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h20, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h01, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h00, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		script.push_back('{'{8'h00, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b0, NO_RECT});
		// A zero byte in the strip phase ends the region; all fields are zero.
		script.push_back('{'{8'h00, 1'b0, 12'd0, 12'd0, 16'h0000, 1'b0}, 1'b1,
			'{KIND_END, 12'd0, 12'd0, 8'd0, 8'd0, 16'h0000}});

		burst_left = $urandom_range(1, 8);
		foreach (script[i]) begin
			offer(script[i].item, script[i].fixed, script[i].want);
		end

		// Random regions. About halfway through, the sender stops once and
		// waits for every owed command before going on.
		while (bytes_parsed < script.size() + RANDOM_BYTES) begin
			if (!drained && bytes_parsed >= script.size() + RANDOM_BYTES / 2) begin
				drain_req = 1'b1;
				drained = 1'b1;
			end
			random_region();
		end

		item_valid <= 1'b0;
		while (pending_rects.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Run limit: far beyond the slowest correct run of this stimulus.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rsd_pkg.sv
rtl/core/rsd_parse.sv
rtl/core/region_strip_decoder_unit.sv
rtl/core/rsd_checker.sv
dv/testbench.sv
